>>> sv/pproj_pkg.sv
// shared types and constants for the pinhole point projection unit
// register map codes, reset values and the divider control structs; no dependencies
package pproj_pkg;

  // configuration port geometry: eight registers at 8-byte spacing
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;

  // rotation entries are signed q2.14, three per 48-bit row
  localparam int ROT_W    = 16;
  localparam int ROT_FRAC = 14;
  localparam int ROW_W    = 48;

  // fraction bits of every q16.16 register
  localparam int Q16_FRAC = 16;

  typedef enum logic [2:0] {
    REG_ROT0      = 3'd0,
    REG_ROT1      = 3'd1,
    REG_ROT2      = 3'd2,
    REG_TRANS_X   = 3'd3,
    REG_TRANS_Y   = 3'd4,
    REG_TRANS_Z   = 3'd5,
    REG_FOCAL     = 3'd6,
    REG_PRINCIPAL = 3'd7
  } reg_idx_t;

  // identity rotation, zero translation, unit focal lengths
  localparam logic [ROW_W-1:0]  ROT0_RST  = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0]  ROT1_RST  = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0]  ROT2_RST  = 48'h4000_0000_0000;
  localparam logic [CFG_DW-1:0] FOCAL_RST = 64'h0001_0000_0001_0000;

  // sideband that enters the divider pipe
  typedef struct packed {
    logic valid;
    logic zero_depth;
    logic neg_u;
    logic neg_v;
  } div_ctl_t;

  // sideband that leaves the divider pipe, with quotient overflow flags
  typedef struct packed {
    logic valid;
    logic zero_depth;
    logic neg_u;
    logic neg_v;
    logic ovf_u;
    logic ovf_v;
  } div_res_t;

endpackage

>>> sv/pproj_in_if.sv
// input channel of the projection unit: one world point per transaction
// valid/ready handshake; depends on nothing
interface pproj_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_world;
  logic signed [COORD_WIDTH-1:0] y_world;
  logic signed [COORD_WIDTH-1:0] z_world;

  modport source (output valid, output x_world, output y_world, output z_world, input ready);
  modport sink   (input valid, input x_world, input y_world, input z_world, output ready);
endinterface

>>> sv/pproj_out_if.sv
// result channel of the projection unit: pixel position and depth per transaction
// valid/ready handshake; depends on nothing
interface pproj_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pixel_u;
  logic signed [COORD_WIDTH-1:0] pixel_v;
  logic signed [COORD_WIDTH-1:0] cam_depth;
  logic                          zero_depth;

  modport source (output valid, output pixel_u, output pixel_v, output cam_depth,
                  output zero_depth, input ready);
  modport sink   (input valid, input pixel_u, input pixel_v, input cam_depth,
                  input zero_depth, output ready);
endinterface

>>> sv/pproj_divider.sv
// pipelined restoring divider for the u and v lanes, one quotient bit per stage
// both lanes share one divisor; uses pproj_pkg
module pproj_divider #(
  parameter int CW = 32,
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  pproj_pkg::div_ctl_t ctl_in,
  input  logic [NW-1:0]       num_u,
  input  logic [NW-1:0]       num_v,
  input  logic [DW-1:0]       den,
  input  logic [CW-1:0]       depth_in,
  output pproj_pkg::div_res_t res_out,
  output logic [CW-1:0]       quo_u,
  output logic [CW-1:0]       quo_v,
  output logic [CW-1:0]       depth_out
);

  localparam int HW = NW - CW;
  localparam int MW = (HW > DW) ? HW : DW;

  pproj_pkg::div_res_t res_r   [CW+1];
  logic [DW-1:0]       rem_u_r [CW+1];
  logic [DW-1:0]       rem_v_r [CW+1];
  logic [CW-1:0]       nq_u_r  [CW+1];
  logic [CW-1:0]       nq_v_r  [CW+1];
  logic [CW-1:0]       depth_r [CW+1];
  logic [DW-1:0]       den_r   [CW];

  logic ovf_u_nxt;
  logic ovf_v_nxt;

  // quotient needs no more than CW bits unless the high part already reaches the divisor
  assign ovf_u_nxt = MW'(num_u[NW-1:CW]) >= MW'(den);
  assign ovf_v_nxt = MW'(num_v[NW-1:CW]) >= MW'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r[0] <= '0;
    end else if (en) begin
      res_r[0] <= '{valid: ctl_in.valid, zero_depth: ctl_in.zero_depth,
                    neg_u: ctl_in.neg_u, neg_v: ctl_in.neg_v,
                    ovf_u: ovf_u_nxt, ovf_v: ovf_v_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_u_r[0] <= DW'(num_u[NW-1:CW]);
      rem_v_r[0] <= DW'(num_v[NW-1:CW]);
      nq_u_r[0]  <= num_u[CW-1:0];
      nq_v_r[0]  <= num_v[CW-1:0];
      den_r[0]   <= den;
      depth_r[0] <= depth_in;
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_step
    logic [DW:0] trial_u;
    logic [DW:0] trial_v;
    logic        bit_u;
    logic        bit_v;

    // shift the next numerator bit into the remainder, subtract when it fits
    always_comb begin
      trial_u = {rem_u_r[k], nq_u_r[k][CW-1]};
      trial_v = {rem_v_r[k], nq_v_r[k][CW-1]};
      bit_u   = trial_u >= {1'b0, den_r[k]};
      bit_v   = trial_v >= {1'b0, den_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        res_r[k+1] <= '0;
      end else if (en) begin
        res_r[k+1] <= res_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_u_r[k+1] <= bit_u ? DW'(trial_u - {1'b0, den_r[k]}) : trial_u[DW-1:0];
        rem_v_r[k+1] <= bit_v ? DW'(trial_v - {1'b0, den_r[k]}) : trial_v[DW-1:0];
        nq_u_r[k+1]  <= {nq_u_r[k][CW-2:0], bit_u};
        nq_v_r[k+1]  <= {nq_v_r[k][CW-2:0], bit_v};
        depth_r[k+1] <= depth_r[k];
      end
    end

    if (k < CW - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign res_out   = res_r[CW];
  assign quo_u     = nq_u_r[CW];
  assign quo_v     = nq_v_r[CW];
  assign depth_out = depth_r[CW];

endmodule

>>> sv/pinhole_point_projection_unit.sv
// top level of the pinhole point projection unit: registers, rotation, projection pipe
// depends on pproj_pkg, pproj_in_if, pproj_out_if and pproj_divider
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+------------------------------------
//   in_ch    | in        | valid & ready              | x_world, y_world, z_world
//   out_ch   | out       | valid & ready              | pixel_u, pixel_v, cam_depth, zero_depth
//   apb cfg  | in        | psel & penable & pwrite    | paddr (8*index), pwdata, prdata
//
// one point enters per cycle unless the output stalls; the restoring divider resolves
// one quotient bit per stage
// the whole pipe advances together whenever the output register is empty or being taken
// a stall freezes every stage in place, so no transaction is dropped or repeated
// synchronous active-low reset clears the valid bits and loads the register defaults
module pinhole_point_projection_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pproj_in_if.sink                       in_ch,
  pproj_out_if.source                    out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pproj_pkg::CFG_AW-1:0]   paddr,
  input  logic [pproj_pkg::CFG_DW-1:0]   pwdata,
  output logic [pproj_pkg::CFG_DW-1:0]   prdata,
  output logic                           pready
);

  localparam int CW  = COORD_WIDTH;
  // q16.16 registers move to the coordinate format by a left or a floor right shift
  localparam int NSH = (FRAC_BITS >= pproj_pkg::Q16_FRAC) ? FRAC_BITS - pproj_pkg::Q16_FRAC : 0;
  localparam int RSH = (FRAC_BITS <  pproj_pkg::Q16_FRAC) ? pproj_pkg::Q16_FRAC - FRAC_BITS : 0;
  localparam int PW  = CW + pproj_pkg::ROT_W;        // one rotation product
  localparam int SW  = PW + 2;                       // sum of three products
  localparam int TW  = 32 + NSH;                     // converted q16.16 value
  localparam int AW  = ((CW + 4 > TW) ? CW + 4 : TW) + 1;
  localparam int HL  = CW / 2;                       // focal multiply split point
  localparam int HH  = CW - HL;
  localparam int NW  = 32 + CW + NSH;                // dividend f*|c| scaled
  localparam int DW  = CW + RSH;                     // divisor |z| scaled
  localparam int BW  = ((CW + 1 > TW) ? CW + 1 : TW) + 1;

  localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [pproj_pkg::ROW_W-1:0]  rot_r   [3];
  logic [31:0]                  trans_r [3];
  logic [pproj_pkg::CFG_DW-1:0] focal_r;
  logic [pproj_pkg::CFG_DW-1:0] pp_r;

  pproj_pkg::reg_idx_t reg_idx;
  logic                cfg_wr;

  assign reg_idx = pproj_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]   <= pproj_pkg::ROT0_RST;
      rot_r[1]   <= pproj_pkg::ROT1_RST;
      rot_r[2]   <= pproj_pkg::ROT2_RST;
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
      focal_r    <= pproj_pkg::FOCAL_RST;
      pp_r       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pproj_pkg::REG_ROT0:      rot_r[0]   <= pwdata[pproj_pkg::ROW_W-1:0];
        pproj_pkg::REG_ROT1:      rot_r[1]   <= pwdata[pproj_pkg::ROW_W-1:0];
        pproj_pkg::REG_ROT2:      rot_r[2]   <= pwdata[pproj_pkg::ROW_W-1:0];
        pproj_pkg::REG_TRANS_X:   trans_r[0] <= pwdata[31:0];
        pproj_pkg::REG_TRANS_Y:   trans_r[1] <= pwdata[31:0];
        pproj_pkg::REG_TRANS_Z:   trans_r[2] <= pwdata[31:0];
        pproj_pkg::REG_FOCAL:     focal_r    <= pwdata;
        pproj_pkg::REG_PRINCIPAL: pp_r       <= pwdata;
        default: ;
      endcase
    end
  end

  // read back, zero-extended to the bus width
  always_comb begin
    unique case (reg_idx)
      pproj_pkg::REG_ROT0:      prdata = pproj_pkg::CFG_DW'(rot_r[0]);
      pproj_pkg::REG_ROT1:      prdata = pproj_pkg::CFG_DW'(rot_r[1]);
      pproj_pkg::REG_ROT2:      prdata = pproj_pkg::CFG_DW'(rot_r[2]);
      pproj_pkg::REG_TRANS_X:   prdata = pproj_pkg::CFG_DW'(trans_r[0]);
      pproj_pkg::REG_TRANS_Y:   prdata = pproj_pkg::CFG_DW'(trans_r[1]);
      pproj_pkg::REG_TRANS_Z:   prdata = pproj_pkg::CFG_DW'(trans_r[2]);
      pproj_pkg::REG_FOCAL:     prdata = focal_r;
      pproj_pkg::REG_PRINCIPAL: prdata = pp_r;
      default:                  prdata = '0;
    endcase
  end

  // translation and principal point in coordinate format; one of the shifts is always zero
  logic signed [TW-1:0] tconv  [3];
  logic signed [TW-1:0] ppconv [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tconv[i] = (TW'(signed'(trans_r[i])) <<< NSH) >>> RSH;
    end
    for (int i = 0; i < 2; i++) begin
      ppconv[i] = (TW'(signed'(pp_r[32*i +: 32])) <<< NSH) >>> RSH;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline enable: every stage moves when the output slot frees up
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic en;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------------------
  // s1: nine rotation products
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] pin [3];
  logic signed [PW-1:0] prod_r [3][3];
  logic                 v1_r;

  assign pin[0] = in_ch.x_world;
  assign pin[1] = in_ch.y_world;
  assign pin[2] = in_ch.z_world;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[r][i] <= signed'(rot_r[r][pproj_pkg::ROT_W*i +: pproj_pkg::ROT_W]) * pin[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // s2: exact row sums
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] sum_r [3];
  logic                 v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= SW'(prod_r[r][0]) + SW'(prod_r[r][1]) + SW'(prod_r[r][2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // s3: floor by 2^14, add translation, saturate to the coordinate range
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] rot_sh  [3];
  logic signed [AW-1:0] cam_sum [3];
  logic [CW-1:0]        cam_nxt [3];
  logic [CW-1:0]        cam_r   [3];
  logic                 v3_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rot_sh[r]  = sum_r[r] >>> pproj_pkg::ROT_FRAC;
      cam_sum[r] = AW'(rot_sh[r]) + AW'(tconv[r]);
      // in range when every bit from the sign down to bit CW-1 agrees
      cam_nxt[r] = ((&cam_sum[r][AW-1:CW-1]) || !(|cam_sum[r][AW-1:CW-1]))
                   ? cam_sum[r][CW-1:0]
                   : {cam_sum[r][AW-1], {(CW-1){~cam_sum[r][AW-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        cam_r[r] <= cam_nxt[r];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // s4: magnitudes and result signs
  // ---------------------------------------------------------------------------
  pproj_pkg::div_ctl_t ctl4_r;
  logic [CW-1:0]       mag4_r [2];
  logic [CW-1:0]       magz4_r;
  logic [CW-1:0]       depth4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        mag4_r[i] <= cam_r[i][CW-1] ? -cam_r[i] : cam_r[i];
      end
      magz4_r  <= cam_r[2][CW-1] ? -cam_r[2] : cam_r[2];
      depth4_r <= cam_r[2];
    end
  end

  // ---------------------------------------------------------------------------
  // s5: focal length times magnitude, as two partial products per lane
  // ---------------------------------------------------------------------------
  pproj_pkg::div_ctl_t ctl5_r;
  logic [31+HL:0]      plo_r [2];
  logic [31+HH:0]      phi_r [2];
  logic [CW-1:0]       magz5_r;
  logic [CW-1:0]       depth5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        plo_r[i] <= focal_r[32*i +: 32] * mag4_r[i][HL-1:0];
        phi_r[i] <= focal_r[32*i +: 32] * mag4_r[i][CW-1:HL];
      end
      magz5_r  <= magz4_r;
      depth5_r <= depth4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // s6: dividend assembly
  // ---------------------------------------------------------------------------
  pproj_pkg::div_ctl_t ctl6_r;
  logic [NW-1:0]       num6_r [2];
  logic [CW-1:0]       magz6_r;
  logic [CW-1:0]       depth6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        num6_r[i] <= (NW'(plo_r[i]) + (NW'(phi_r[i]) << HL)) << NSH;
      end
      magz6_r  <= magz5_r;
      depth6_r <= depth5_r;
    end
  end

  // valid and sideband through the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else if (en) begin
      v1_r   <= in_ch.valid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      ctl4_r <= '{valid: v3_r, zero_depth: cam_r[2] == '0,
                  neg_u: cam_r[0][CW-1] ^ cam_r[2][CW-1],
                  neg_v: cam_r[1][CW-1] ^ cam_r[2][CW-1]};
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // divider: floor(f*|c| / |z|) with the fixed-point scaling folded into both sides
  // ---------------------------------------------------------------------------
  pproj_pkg::div_res_t div_res;
  logic [CW-1:0]       quo_u;
  logic [CW-1:0]       quo_v;
  logic [CW-1:0]       depth_div;

  pproj_divider #(
    .CW (CW),
    .NW (NW),
    .DW (DW)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (ctl6_r),
    .num_u     (num6_r[0]),
    .num_v     (num6_r[1]),
    .den       (DW'(magz6_r) << RSH),
    .depth_in  (depth6_r),
    .res_out   (div_res),
    .quo_u     (quo_u),
    .quo_v     (quo_v),
    .depth_out (depth_div)
  );

  // ---------------------------------------------------------------------------
  // f1: clamp the magnitude, one step further for negative results
  // ---------------------------------------------------------------------------
  logic [CW-1:0]       quo    [2];
  logic                ovf    [2];
  logic                neg_dv [2];
  logic [CW-1:0]       lim    [2];
  logic [CW-1:0]       qlim_nxt [2];
  pproj_pkg::div_ctl_t ctl_f1_r;
  logic [CW-1:0]       qlim_r [2];
  logic [CW-1:0]       depth_f1_r;

  always_comb begin
    quo[0]    = quo_u;
    quo[1]    = quo_v;
    ovf[0]    = div_res.ovf_u;
    ovf[1]    = div_res.ovf_v;
    neg_dv[0] = div_res.neg_u;
    neg_dv[1] = div_res.neg_v;
    for (int i = 0; i < 2; i++) begin
      lim[i]      = neg_dv[i] ? LIM_NEG : LIM_POS;
      qlim_nxt[i] = (ovf[i] || quo[i] > lim[i]) ? lim[i] : quo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_f1_r <= '0;
    end else if (en) begin
      ctl_f1_r <= '{valid: div_res.valid, zero_depth: div_res.zero_depth,
                    neg_u: div_res.neg_u, neg_v: div_res.neg_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qlim_r[0]  <= qlim_nxt[0];
      qlim_r[1]  <= qlim_nxt[1];
      depth_f1_r <= depth_div;
    end
  end

  // ---------------------------------------------------------------------------
  // f2: apply sign, add principal point (zero for zero depth), saturate into the output register
  // ---------------------------------------------------------------------------
  logic                 neg_f1  [2];
  logic signed [BW-1:0] pix_sum [2];
  logic [CW-1:0]        pix_nxt [2];
  logic [CW-1:0]        pixel_u_r;
  logic [CW-1:0]        pixel_v_r;
  logic [CW-1:0]        cam_depth_r;
  logic                 zero_depth_r;

  always_comb begin
    neg_f1[0] = ctl_f1_r.neg_u;
    neg_f1[1] = ctl_f1_r.neg_v;
    for (int i = 0; i < 2; i++) begin
      pix_sum[i] = neg_f1[i] ? BW'(ppconv[i]) - BW'(qlim_r[i])
                             : BW'(ppconv[i]) + BW'(qlim_r[i]);
      if (ctl_f1_r.zero_depth) begin
        pix_nxt[i] = '0;
      end else if ((&pix_sum[i][BW-1:CW-1]) || !(|pix_sum[i][BW-1:CW-1])) begin
        pix_nxt[i] = pix_sum[i][CW-1:0];
      end else begin
        pix_nxt[i] = {pix_sum[i][BW-1], {(CW-1){~pix_sum[i][BW-1]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_f1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_u_r    <= pix_nxt[0];
      pixel_v_r    <= pix_nxt[1];
      cam_depth_r  <= depth_f1_r;
      zero_depth_r <= ctl_f1_r.zero_depth;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_u    = pixel_u_r;
  assign out_ch.pixel_v    = pixel_v_r;
  assign out_ch.cam_depth  = cam_depth_r;
  assign out_ch.zero_depth = zero_depth_r;

endmodule
